@@ rtl/trd_pkg.sv @@
// Shared types and constants for the touch report decoder.
package trd_pkg;

	// Request that enters the decoder: one raw report byte.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} byte_req_t;

	// Request that leaves the decoder: one slot result.
	typedef struct packed {
		logic [2:0]  slot;
		logic [1:0]  slot_state;
		logic [11:0] pos_x;
		logic [11:0] pos_y;
		logic [3:0]  pressure;
		logic        last_slot;
	} slot_rpt_t;

	// Slot state codes.
	localparam logic [1:0] SLOT_UP        = 2'd0;
	localparam logic [1:0] SLOT_DOWN      = 2'd1;
	localparam logic [1:0] SLOT_NO_CHANGE = 2'd2;

	// Mask bits that count as a touch for the empty report test.
	localparam logic [7:0] TOUCH_MASK = 8'hf8;

	// Register map: register index is paddr[2].
	localparam int         PADDR_W            = 3;
	localparam logic       REG_RELEASE_HOLD   = 1'b0;
	localparam logic [3:0] RELEASE_HOLD_RESET = 4'd2;

	// Byte positions in a report.
	localparam int MASK_BYTE  = 1;
	localparam int SLOT_START = 3;

endpackage

@@ rtl/trd_cfg_regs.sv @@
// Configuration register block of the touch report decoder (APB-style port).
module trd_cfg_regs
	import trd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output logic [3:0]         release_hold
);

	logic [3:0] release_hold_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_RELEASE_HOLD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			release_hold_q <= RELEASE_HOLD_RESET;
		end else if (wr_en) begin
			release_hold_q <= pwdata[3:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == REG_RELEASE_HOLD) begin
			prdata = {28'd0, release_hold_q};
		end
	end

	assign release_hold = release_hold_q;

endmodule

@@ rtl/trd_frame_decoder.sv @@
// Report byte decoder: report position, finger masks, release hold and slot results.
module trd_frame_decoder
	import trd_pkg::*;
#(
	parameter int SLOTS = 5
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  byte_req_t byte_in,
	input  logic [3:0] release_hold,
	output logic      res_valid,
	output slot_rpt_t res
);

	localparam int REPORT_LEN = 4 * SLOTS + 3;
	localparam int IDX_W      = $clog2(REPORT_LEN + 1);
	localparam int SLOT_IDX_W = IDX_W - 2;

	localparam logic [IDX_W-1:0]      LEN_C    = IDX_W'(REPORT_LEN);
	localparam logic [IDX_W-1:0]      MASK_C   = IDX_W'(MASK_BYTE);
	localparam logic [IDX_W-1:0]      START_C  = IDX_W'(SLOT_START);
	localparam logic [SLOT_IDX_W-1:0] LAST_C   = SLOT_IDX_W'(SLOTS - 1);

	logic [IDX_W-1:0] byte_index_q;
	logic [7:0]       held_mask_q;
	logic [4:0]       quiet_count_q;
	logic [7:0]       current_mask_q;
	logic             release_valid_q;
	logic [7:0]       high_nibbles_q;
	logic [7:0]       x_low_byte_q;
	logic [7:0]       y_low_byte_q;

	logic [IDX_W-1:0]      idx;
	logic [IDX_W-1:0]      off;
	logic [1:0]            pos;
	logic [SLOT_IDX_W-1:0] s_idx;
	logic [2:0]            slot_no;
	logic                  in_report;
	logic                  is_mask;
	logic                  is_slot;
	logic                  is_last;
	logic                  finger_on;
	logic                  finger_chg;
	logic [4:0]            quiet_inc;
	logic                  quiet_over;
	logic                  empty_mask;

	assign idx        = byte_in.frame_start ? '0 : byte_index_q;
	assign in_report  = idx < LEN_C;
	assign is_mask    = idx == MASK_C;
	assign is_slot    = idx >= START_C;
	assign off        = idx - START_C;
	assign pos        = off[1:0];
	assign s_idx      = off[IDX_W-1:2];
	assign slot_no    = 3'(s_idx);
	assign is_last    = s_idx == LAST_C;
	assign finger_on  = current_mask_q[3'd7 - slot_no];
	assign finger_chg = held_mask_q[3'd7 - slot_no] != finger_on;
	assign empty_mask = (byte_in.data_byte & TOUCH_MASK) == 8'd0;
	assign quiet_inc  = quiet_count_q + 5'd1;
	assign quiet_over = quiet_inc > {1'b0, release_hold};

	// A result leaves on the pressure byte of every slot.
	assign res_valid = step && in_report && is_slot && (pos == 2'd3);

	always_comb begin
		res           = '0;
		res.slot      = slot_no;
		res.last_slot = is_last;
		if (finger_on) begin
			res.slot_state = SLOT_DOWN;
			res.pos_x      = {high_nibbles_q[7:4], x_low_byte_q};
			res.pos_y      = {high_nibbles_q[3:0], y_low_byte_q};
			res.pressure   = byte_in.data_byte[3:0];
		end else if (finger_chg && release_valid_q) begin
			res.slot_state = SLOT_UP;
		end else begin
			res.slot_state = SLOT_NO_CHANGE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q    <= '0;
			held_mask_q     <= '0;
			quiet_count_q   <= '0;
			current_mask_q  <= '0;
			release_valid_q <= 1'b0;
			high_nibbles_q  <= '0;
			x_low_byte_q    <= '0;
			y_low_byte_q    <= '0;
		end else if (step && in_report) begin
			byte_index_q <= idx + IDX_W'(1);
			if (is_mask) begin
				current_mask_q <= byte_in.data_byte;
				if (!empty_mask) begin
					quiet_count_q   <= '0;
					release_valid_q <= 1'b1;
				end else if (quiet_over) begin
					quiet_count_q   <= '0;
					release_valid_q <= 1'b1;
				end else begin
					quiet_count_q   <= quiet_inc;
					release_valid_q <= 1'b0;
				end
			end else if (is_slot) begin
				case (pos)
					2'd0: high_nibbles_q <= byte_in.data_byte;
					2'd1: x_low_byte_q   <= byte_in.data_byte;
					2'd2: y_low_byte_q   <= byte_in.data_byte;
					default: begin
						if (is_last && release_valid_q) begin
							held_mask_q <= current_mask_q;
						end
					end
				endcase
			end
		end else if (step && byte_in.frame_start) begin
			byte_index_q <= IDX_W'(1);
		end
	end

endmodule

@@ rtl/touch_report_decoder.sv @@
// Top level of the touch report decoder: input register, decoder and result register.
//
// Decodes a touch controller report that arrives one byte per request: frame_start marks
// byte 0, byte 1 is the finger mask (slot i uses bit 7-i), byte 2 is skipped and each slot
// then takes four bytes (high nibbles, x low, y low, pressure). On every pressure byte one
// slot result leaves: down with 12-bit x/y and pressure, up, or no change; bytes from index
// 4*SLOTS+3 on are dropped. A mask with none of the top five bits set counts as an empty report,
// and a release is accepted at once after a non-empty mask, else only once more than
// release_hold such reports arrive in a row. Timing: one byte per clock is sustained while
// slot_stall is low. A byte is held in the input register, is decoded in a single pass and
// its result is shown from the result register. The input register and the result register
// decouple the two sides: a new byte is taken while a result waits, and byte_stall rises
// only when both registers are full and slot_stall is high. Register release_hold sits at
// byte address 0 and is written through the APB-style port.
module touch_report_decoder
	import trd_pkg::*;
#(
	parameter int SLOTS = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  byte_req_t          byte_req,
	output logic               slot_valid,
	input  logic               slot_stall,
	output slot_rpt_t          slot_rpt,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic       valid_s1;
	byte_req_t  req_s1;
	logic       out_valid_q;
	slot_rpt_t  out_rpt_q;
	logic [3:0] release_hold;
	logic       advance;
	logic       step;
	logic       load_s1;
	logic       res_valid;
	slot_rpt_t  res;

	trd_cfg_regs u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.release_hold (release_hold)
	);

	// The result register can take a new result when empty or being drained.
	assign advance    = !out_valid_q || !slot_stall;
	// Decode the held byte once the result side can take what it produces.
	assign step       = valid_s1 && advance;
	// Hold off the sender only while the input register is full and cannot move.
	assign byte_stall = valid_s1 && !advance;
	assign load_s1    = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			req_s1 <= byte_req;
		end
	end

	trd_frame_decoder #(
		.SLOTS (SLOTS)
	) u_dec (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.byte_in      (req_s1),
		.release_hold (release_hold),
		.res_valid    (res_valid),
		.res          (res)
	);

	// Load a fresh result, or drop the shown one once it has been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_rpt_q <= res;
		end
	end

	assign slot_valid = out_valid_q;
	assign slot_rpt   = out_rpt_q;

	// Only a slot that exists is ever reported.
	assert property (@(posedge clk) disable iff (!arst_n)
		slot_valid |-> (32'(slot_rpt.slot) < SLOTS))
		else $error("slot result beyond configured slot count");

	// The last flag marks exactly the final slot of a report.
	assert property (@(posedge clk) disable iff (!arst_n)
		slot_valid |-> (slot_rpt.last_slot == (32'(slot_rpt.slot) == SLOTS - 1)))
		else $error("last_slot does not match slot number");

	// Up and no-change results carry no position or pressure.
	assert property (@(posedge clk) disable iff (!arst_n)
		(slot_valid && (slot_rpt.slot_state != SLOT_DOWN)) |->
		(slot_rpt.pos_x == 12'd0 && slot_rpt.pos_y == 12'd0 && slot_rpt.pressure == 4'd0))
		else $error("payload not cleared on non-down result");

	// A stalled input means the input register is full and the result side is blocked.
	assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (valid_s1 && out_valid_q && slot_stall))
		else $error("input stalled without a blocked pipeline");

endmodule
